@@ sv/lcg_ranged_integer_generator_macros.svh @@
// assertion macros for the ranged lcg generator checker
// no dependencies; included by the checker file
`ifndef LCG_RANGED_INTEGER_GENERATOR_MACROS_SVH
`define LCG_RANGED_INTEGER_GENERATOR_MACROS_SVH

// same-cycle implication, inactive during reset
`define LCGRIG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, inactive during reset
`define LCGRIG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define LCGRIG_ASSERT_NXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lcgrig_pkg.sv @@
// shared types and constants for the ranged lcg generator
// no dependencies; imported by every module of the block
package lcgrig_pkg;

  localparam int unsigned STATE_W   = 31;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ALU_W     = 34;
  localparam int unsigned MUL_STEPS = 31;
  localparam int unsigned ACC_W     = 63;

  localparam logic [STATE_W-1:0] START_VALUE = 31'd881726454;
  localparam logic [STATE_W-1:0] LCG_MUL     = 31'd1103515245;
  localparam logic [STATE_W-1:0] LCG_ADD     = 31'd12345;
  localparam logic [STATE_W-1:0] LCG_MOD     = 31'h7FFF_FFFF;

  localparam logic OP_INCLUSIVE = 1'b0;
  localparam logic OP_HALF_OPEN = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drawn_value;
    logic [30:0]        raw_draw;
  } out_item_t;

  typedef struct packed {
    logic sub;
    logic cin;
  } alu_ctrl_t;

endpackage

@@ sv/lcgrig_alu.sv @@
// shared add / subtract / compare unit of the ranged lcg generator
// depends on lcgrig_pkg; carry out high on subtract means opa >= opb
module lcgrig_alu import lcgrig_pkg::*; (
  input  logic [ALU_W-1:0] opa,
  input  logic [ALU_W-1:0] opb,
  input  alu_ctrl_t        ctrl,
  output logic [ALU_W-1:0] sum,
  output logic             carry
);

  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   full;

  assign b_eff = ctrl.sub ? ~opb : opb;
  assign full  = {1'b0, opa} + {1'b0, b_eff} + {{ALU_W{1'b0}}, (ctrl.sub | ctrl.cin)};
  assign sum   = full[ALU_W-1:0];
  assign carry = full[ALU_W];

endmodule

@@ sv/lcg_ranged_integer_generator.sv @@
// top level of the ranged lcg generator: sequencer, datapath registers and output stage
// depends on lcgrig_pkg and lcgrig_alu
//
// requests arrive on in_valid/in_ready with in_item (mode, low bound, high bound);
// each request gives one result on out_valid/out_ready with out_item (drawn value and
// the generator state after the request). the seed is written on cfg_valid/cfg_ready
// with cfg_seed while the block is idle; a seed of 0 loads the built-in start value.
// one 34-bit adder is reused for every step: span set-up (high minus low, then the
// inclusive increment), a shift-add multiply by the lcg constant (one multiplier bit
// per cycle), folding mod 2^31-1 (add the halves, add the carry back, subtract the
// modulus if reached), a restoring modulo by the span (one bit per cycle) and the
// final offset add. an empty inclusive draw skips the modulo and the offset add, and
// an empty half-open draw goes straight from the difference to the result.
// in_ready is high only while the sequencer is idle, so one request is in work at
// a time. the finished result sits in an output register: a stalled receiver holds
// out_item steady, and the next request may be taken meanwhile, its result waiting
// in the sequencer until the output register frees.
// reset (rst_n low, synchronous) empties the output register, idles the sequencer
// and loads the generator state with the start value.
module lcg_ranged_integer_generator import lcgrig_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [STATE_W-1:0]   cfg_seed
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_SPAN  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_FOLD1 = 4'd4;
  localparam logic [3:0] S_FOLD2 = 4'd5;
  localparam logic [3:0] S_RED   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_ADD   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [4:0] LAST_STEP = 5'(MUL_STEPS - 1);

  logic [3:0]          state_r, state_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                op_r, op_nxt;
  logic signed [31:0]  lo_r, lo_nxt;
  logic signed [31:0]  hi_r, hi_nxt;
  logic [ALU_W-1:0]    span_r, span_nxt;
  logic                empty_r, empty_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [ALU_W-1:0]    tmp_r, tmp_nxt;
  logic [ALU_W-1:0]    rem_r, rem_nxt;
  logic [STATE_W-1:0]  gen_r, gen_nxt;
  logic [DATA_W-1:0]   res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic [ALU_W-1:0]    alu_a, alu_b, alu_sum;
  alu_ctrl_t           alu_ctrl;
  logic                alu_carry;
  logic [4:0]          div_idx;
  logic                diff_empty;

  lcgrig_alu u_alu (
    .opa   (alu_a),
    .opb   (alu_b),
    .ctrl  (alu_ctrl),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;
  assign div_idx    = LAST_STEP - cnt_r;
  assign diff_empty = alu_sum[ALU_W-1] | (alu_sum == '0);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    span_nxt      = span_r;
    empty_nxt     = empty_r;
    acc_nxt       = acc_r;
    tmp_nxt       = tmp_r;
    rem_nxt       = rem_r;
    gen_nxt       = gen_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_ctrl      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          gen_nxt = (cfg_seed == '0) ? START_VALUE : cfg_seed;
        end
        if (in_valid) begin
          op_nxt    = in_item.operation;
          lo_nxt    = in_item.range_low;
          hi_nxt    = in_item.range_high;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        // high - low, sign extended so the full signed span fits
        alu_a        = {{2{hi_r[31]}}, hi_r};
        alu_b        = {{2{lo_r[31]}}, lo_r};
        alu_ctrl.sub = 1'b1;
        span_nxt     = alu_sum;
        empty_nxt    = diff_empty;
        if (diff_empty && (op_r == OP_HALF_OPEN)) begin
          res_nxt   = lo_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SPAN;
        end
      end
      S_SPAN: begin
        alu_a        = span_r;
        alu_ctrl.cin = (op_r == OP_INCLUSIVE);
        span_nxt     = alu_sum;
        // increment rides in the top half and lands at the bottom after the shifts
        acc_nxt      = {1'b0, LCG_ADD, {STATE_W{1'b0}}};
        cnt_nxt      = '0;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        alu_a   = {2'b00, acc_r[ACC_W-1:STATE_W]};
        alu_b   = LCG_MUL[cnt_r] ? {3'b000, gen_r} : '0;
        acc_nxt = {alu_sum[32:0], acc_r[STATE_W-1:1]};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_FOLD1;
        end
      end
      S_FOLD1: begin
        // 2^31 is 1 mod 2^31-1, so the halves simply add
        alu_a     = {3'b000, acc_r[61:STATE_W]};
        alu_b     = {3'b000, acc_r[STATE_W-1:0]};
        tmp_nxt   = alu_sum;
        state_nxt = S_FOLD2;
      end
      S_FOLD2: begin
        alu_a     = {{(ALU_W-1){1'b0}}, tmp_r[STATE_W]};
        alu_b     = {3'b000, tmp_r[STATE_W-1:0]};
        tmp_nxt   = alu_sum;
        state_nxt = S_RED;
      end
      S_RED: begin
        alu_a        = tmp_r;
        alu_b        = {3'b000, LCG_MOD};
        alu_ctrl.sub = 1'b1;
        gen_nxt      = alu_carry ? alu_sum[STATE_W-1:0] : tmp_r[STATE_W-1:0];
        rem_nxt      = '0;
        cnt_nxt      = '0;
        if (empty_r) begin
          res_nxt   = lo_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring step: trial subtract of the span, keep on no borrow
        alu_a        = {rem_r[ALU_W-2:0], gen_r[div_idx]};
        alu_b        = span_r;
        alu_ctrl.sub = 1'b1;
        rem_nxt      = alu_carry ? alu_sum : alu_a;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        alu_a     = {2'b00, lo_r};
        alu_b     = {2'b00, rem_r[DATA_W-1:0]};
        res_nxt   = alu_sum[DATA_W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.drawn_value = res_r;
          out_item_nxt.raw_draw    = gen_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gen_r       <= START_VALUE;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gen_r       <= gen_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    span_r     <= span_nxt;
    empty_r    <= empty_nxt;
    acc_r      <= acc_nxt;
    tmp_r      <= tmp_nxt;
    rem_r      <= rem_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

@@ sv/lcgrig_checker.sv @@
// port-level checker for the ranged lcg generator, bound to the top level
// depends on lcgrig_pkg and lcg_ranged_integer_generator_macros.svh
`include "lcg_ranged_integer_generator_macros.svh"

module lcgrig_checker import lcgrig_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // reset leaves the output empty and the block ready
  `LCGRIG_ASSERT_NXT_ALWAYS(a_reset_state, !rst_n, (!out_valid && in_ready), "bad state after reset")

  // a stalled result stays put
  `LCGRIG_ASSERT_NXT(a_out_hold, (out_valid && !out_ready), (out_valid && $stable(out_item)), "result changed while stalled")

  // one request in work at a time
  `LCGRIG_ASSERT_NXT(a_busy_after_in, (in_valid && in_ready), !in_ready, "ready straight after an input transfer")

  // no result can appear the cycle after a transfer into an empty block
  `LCGRIG_ASSERT_NXT(a_min_latency, (in_valid && in_ready && !out_valid), !out_valid, "result too early")

endmodule

bind lcg_ranged_integer_generator lcgrig_checker u_lcgrig_checker (.*);

@@ sim/lcg_ranged_integer_generator_tb.sv @@
// testbench for lcg_ranged_integer_generator: directed and random range draws under seed changes
// depends on lcgrig_pkg and the block's rtl; expected draws come from a built-in predictor
module lcg_ranged_integer_generator_tb;
  import lcgrig_pkg::*;

  localparam logic [STATE_W-1:0] SEED_MAX = 31'd2147483646;

  class draw_tracker;
    logic [STATE_W-1:0] lcg_state;
    out_item_t          pending_draws[$];
    int                 mismatches;

    function new();
      lcg_state  = START_VALUE;
      mismatches = 0;
    endfunction

    function void load_seed(logic [STATE_W-1:0] seed);
      lcg_state = (seed == '0) ? START_VALUE : seed;
    endfunction

    function void advance_state();
      longint unsigned prod;
      prod = longint'(lcg_state) * longint'(LCG_MUL) + longint'(LCG_ADD);
      prod = prod % longint'(LCG_MOD);
      lcg_state = prod[STATE_W-1:0];
    endfunction

    function void note_request(in_item_t req);
      longint    lo;
      longint    hi;
      longint    span;
      out_item_t want;
      lo = longint'(req.range_low);
      hi = longint'(req.range_high);
      want.drawn_value = req.range_low;
      if (!(req.operation == OP_HALF_OPEN && hi <= lo)) begin
        if (req.operation == OP_HALF_OPEN) hi = hi - 1;
        advance_state();
        if (hi > lo) begin
          span = hi - lo + 1;
          want.drawn_value = 32'(lo + (longint'(lcg_state) % span));
        end
      end
      want.raw_draw = lcg_state;
      pending_draws.push_back(want);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_draw(out_item_t got);
      out_item_t want;
      if (pending_draws.size() == 0) begin
        report_mismatch($sformatf("unexpected draw value %0d raw %0d",
                                  got.drawn_value, got.raw_draw));
        return;
      end
      want = pending_draws.pop_front();
      if (got.drawn_value !== want.drawn_value)
        report_mismatch($sformatf("drawn_value %0d, expected %0d",
                                  got.drawn_value, want.drawn_value));
      if (got.raw_draw !== want.raw_draw)
        report_mismatch($sformatf("raw_draw %0d, expected %0d",
                                  got.raw_draw, want.raw_draw));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [STATE_W-1:0] cfg_seed;

  draw_tracker draws;
  int          draws_seen;
  logic        quiet;
  logic        squeeze;

  lcg_ranged_integer_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_seed  (cfg_seed)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_cycles();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] boundary_value();
    case ($urandom_range(0, 6))
      0: return 32'sh8000_0000;
      1: return 32'sh8000_0001;
      2: return -32'sd1;
      3: return 32'sd0;
      4: return 32'sd1;
      5: return 32'sh7FFF_FFFE;
      default: return 32'sh7FFF_FFFF;
    endcase
  endfunction

  function automatic in_item_t make_request();
    in_item_t        req;
    longint unsigned span_m1;
    req.operation = $urandom_range(0, 1) ? OP_HALF_OPEN : OP_INCLUSIVE;
    req.range_low = $urandom;
    case ($urandom_range(0, 11))
      0, 1, 2: req.range_high = $urandom;
      3, 4: req.range_high = req.range_low + $urandom_range(0, 300);
      5: begin
        req.range_low  = $urandom_range(0, 200) - 100;
        req.range_high = req.range_low + $urandom_range(0, 60);
      end
      6, 7: begin
        span_m1 = (64'd1 << $urandom_range(0, 32)) - 64'd1;
        req.range_high = req.range_low + span_m1[31:0];
      end
      8: req.range_high = req.range_low;
      9: req.range_high = req.range_low - $urandom_range(1, 1000);
      default: begin
        req.range_low  = boundary_value();
        req.range_high = boundary_value();
      end
    endcase
    return req;
  endfunction

  // entered and left at a falling edge; valid stays up when no gap follows
  task automatic send_request(input in_item_t req);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    draws.note_request(req);
    @(negedge clk);
  endtask

  task automatic send_directed(input logic op, input int lo, input int hi);
    in_item_t req;
    req.operation  = op;
    req.range_low  = lo;
    req.range_high = hi;
    send_request(req);
  endtask

  task automatic drain_draws();
    in_valid = 1'b0;
    while (draws.pending_draws.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_seed(input logic [STATE_W-1:0] seed);
    cfg_valid = 1'b1;
    cfg_seed  = seed;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    draws.load_seed(seed);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off while squeeze is up
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze) begin
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = gap_cycles();
      end
    end
  end

  initial begin
    squeeze = 1'b0;
    wait (draws_seen >= 600);
    @(posedge clk);
    squeeze = 1'b1;
    repeat (400) @(posedge clk);
    squeeze = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      draws.check_draw(out_item);
      draws_seen++;
    end
  end

  initial begin
    #30000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [STATE_W-1:0] seeds[5];
    int                 counts[5];
    draws      = new();
    draws_seen = 0;
    quiet      = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_seed   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed draws from the reset state
    send_directed(OP_INCLUSIVE, 0, 0);
    send_directed(OP_INCLUSIVE, 5, -5);
    send_directed(OP_INCLUSIVE, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_directed(OP_HALF_OPEN, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_directed(OP_HALF_OPEN, 7, 7);
    send_directed(OP_HALF_OPEN, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_directed(OP_HALF_OPEN, 3, 4);
    send_directed(OP_INCLUSIVE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_directed(OP_INCLUSIVE, 32'sh8000_0000, 32'sh8000_0000);
    send_directed(OP_INCLUSIVE, 0, 1);
    send_directed(OP_INCLUSIVE, 0, 25);
    send_directed(OP_INCLUSIVE, -1, 0);
    send_directed(OP_HALF_OPEN, 0, 32'sh7FFF_FFFF);
    send_directed(OP_INCLUSIVE, 32'sh8000_0000, -1);
    send_directed(OP_INCLUSIVE, 0, 32'sh7FFF_FFFF);
    send_directed(OP_HALF_OPEN, 32'sh8000_0000, 32'sh8000_0001);
    send_directed(OP_HALF_OPEN, -10, -20);
    send_directed(OP_INCLUSIVE, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF);
    send_directed(OP_HALF_OPEN, -100, 100);
    send_directed(OP_INCLUSIVE, 1, 0);
    drain_draws();

    seeds[0]  = '0;
    seeds[1]  = 31'd1;
    seeds[2]  = SEED_MAX;
    seeds[3]  = 31'($urandom_range(2, 2147483645));
    seeds[4]  = 31'($urandom_range(2, 2147483645));
    counts[0] = 350;
    counts[1] = 450;
    counts[2] = 400;
    counts[3] = 400;
    counts[4] = 400;
    for (int p = 0; p < 5; p++) begin
      quiet = (p == 0);
      write_seed(seeds[p]);
      repeat (counts[p]) send_request(make_request());
      drain_draws();
    end

    repeat (80) @(posedge clk);
    if (draws.pending_draws.size() != 0)
      draws.report_mismatch($sformatf("%0d draws never returned", draws.pending_draws.size()));
    if (draws.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/lcgrig_pkg.sv
sv/lcgrig_alu.sv
sv/lcg_ranged_integer_generator.sv
sv/lcgrig_checker.sv
sim/lcg_ranged_integer_generator_tb.sv
